// ----- hdl/utcj_pkg.sv -----
package utcj_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int MSEC_W   = 16;
    localparam int OFFSET_W = 44;

    // day count: up to about 767k days, one more bit for the day-zero case
    localparam int DAYS_W   = 21;
    localparam int DOY_W    = 9;
    localparam int ELAPSED_W = 12;
    localparam int Q25_W    = 8;

    localparam int EPOCH_YEAR    = 2000;
    localparam int REF_OFFSET_MS = 43135816;
    localparam int MS_PER_DAY    = 86400000;
    localparam int MS_PER_HOUR   = 3600000;
    localparam int MS_PER_MINUTE = 60000;

    // reciprocal of 25 in q17, exact for operands below 43690
    localparam int RECIP25 = 5243;

    typedef logic [YEAR_W-1:0]    year_t;
    typedef logic [ELAPSED_W-1:0] elapsed_t;
    typedef logic [Q25_W-1:0]     q25_t;
    typedef logic [DOY_W-1:0]     doy_t;

    // per-year terms produced ahead of the day count
    typedef struct packed {
        elapsed_t elapsed;
        q25_t     year_q25;
        q25_t     cent_q25;
        q25_t     quad_q25;
    } year_terms_t;

    function automatic q25_t div25(input logic [YEAR_W-1:0] v);
        logic [YEAR_W+13-1:0] prod;
        begin
            prod = {13'd0, v} * (YEAR_W + 13)'(RECIP25);
            div25 = prod[YEAR_W+13-1:17];
        end
    endfunction

    // days before the month; month zero adds nothing, past twelve the full year
    function automatic doy_t days_before(input logic [MONTH_W-1:0] m);
        begin
            case (m)
                4'd0:    days_before = 9'd0;
                4'd1:    days_before = 9'd0;
                4'd2:    days_before = 9'd31;
                4'd3:    days_before = 9'd59;
                4'd4:    days_before = 9'd90;
                4'd5:    days_before = 9'd120;
                4'd6:    days_before = 9'd151;
                4'd7:    days_before = 9'd181;
                4'd8:    days_before = 9'd212;
                4'd9:    days_before = 9'd243;
                4'd10:   days_before = 9'd273;
                4'd11:   days_before = 9'd304;
                4'd12:   days_before = 9'd334;
                default: days_before = 9'd365;
            endcase
        end
    endfunction

endpackage

// ----- hdl/utcj_date_if.sv -----
interface utcj_date_if;
    import utcj_pkg::*;

    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   calendar_year;
    logic [MONTH_W-1:0]  month_number;
    logic [DAY_W-1:0]    day_of_month;
    logic [HOUR_W-1:0]   hour_of_day;
    logic [MINUTE_W-1:0] minute_of_hour;
    logic [MSEC_W-1:0]   second_millis;

    modport source (
        output valid, calendar_year, month_number, day_of_month,
               hour_of_day, minute_of_hour, second_millis,
        input  ready
    );

    modport sink (
        input  valid, calendar_year, month_number, day_of_month,
               hour_of_day, minute_of_hour, second_millis,
        output ready
    );
endinterface

// ----- hdl/utcj_offset_if.sv -----
interface utcj_offset_if;
    import utcj_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [OFFSET_W-1:0] tt_offset_millis;

    modport source (output valid, tt_offset_millis, input ready);
    modport sink (input valid, tt_offset_millis, output ready);
endinterface

// ----- hdl/utcj_year_terms.sv -----
module utcj_year_terms (
    input  utcj_pkg::year_t       year,
    output utcj_pkg::year_terms_t terms
);
    import utcj_pkg::*;

    elapsed_t           elapsed;
    logic [YEAR_W-1:0]  cent_arg;
    logic [YEAR_W-1:0]  quad_arg;

    always_comb
    begin
        if (year > YEAR_W'(EPOCH_YEAR))
        begin
            elapsed = ELAPSED_W'(year - YEAR_W'(EPOCH_YEAR));
        end
        else
        begin
            elapsed = '0;
        end
        // (n+99)/100 as ((n+99)>>2)/25, (n+399)/400 as ((n+399)>>4)/25
        cent_arg = YEAR_W'(({1'b0, elapsed} + 13'd99) >> 2);
        quad_arg = YEAR_W'(({1'b0, elapsed} + 13'd399) >> 4);

        terms.elapsed  = elapsed;
        terms.year_q25 = div25(year >> 2);
        terms.cent_q25 = div25(cent_arg);
        terms.quad_q25 = div25(quad_arg);
    end
endmodule

// ----- hdl/utc_date_to_j2000_seconds.sv -----
// channel     dir  payload                                         per request
// date_chan   in   year, month, day, hour, minute, second_millis   one date
// offset_chan out  tt_offset_millis (44 bit signed)                one offset
//
// four register stages: input, year terms, day count, result
// one date per cycle sustained while offset_chan.ready stays high
// rst_n clears the stage valid bits only; payload registers are not reset
// a stalled result holds the output register; upstream stages keep filling
// their empty slots, so ready drops only when all four stages hold a request
module utc_date_to_j2000_seconds #(
    parameter int YEAR_SPAN = 256
) (
    input logic         clk,
    input logic         rst_n,
    utcj_date_if.sink   date_chan,
    utcj_offset_if.source offset_chan
);
    import utcj_pkg::*;

    // last year honored; later years clamp to it
    localparam logic [13:0] TOP_YEAR = 14'(EPOCH_YEAR + YEAR_SPAN - 1);

    // stage valid bits and advance enables
    logic in_vld_reg, yt_vld_reg, dc_vld_reg, out_vld_reg;
    logic in_adv, yt_adv, dc_adv, out_adv;

    // input register
    year_t               year_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [DAY_W-1:0]    day_reg;
    logic [HOUR_W-1:0]   hour_reg;
    logic [MINUTE_W-1:0] minute_reg;
    logic [MSEC_W-1:0]   msec_reg;

    // year terms stage
    year_t               yt_year_reg;
    year_terms_t         yt_terms_reg;
    logic [MONTH_W-1:0]  yt_month_reg;
    logic [DAY_W-1:0]    yt_day_reg;
    logic [HOUR_W-1:0]   yt_hour_reg;
    logic [MINUTE_W-1:0] yt_minute_reg;
    logic [MSEC_W-1:0]   yt_msec_reg;

    // day count stage
    logic signed [DAYS_W-1:0] dc_days_reg;
    logic [HOUR_W-1:0]        dc_hour_reg;
    logic [MINUTE_W-1:0]      dc_minute_reg;
    logic [MSEC_W-1:0]        dc_msec_reg;

    // result register
    logic [OFFSET_W-1:0] offset_reg;

    year_t               year_clamped;
    year_terms_t         terms;

    logic [YEAR_W-3:0]    year_quarter;
    logic [ELAPSED_W-1:0] year_rem25;
    logic                 is_century;
    logic                 is_leap;
    doy_t                 doy;
    logic [DAYS_W-1:0]    elapsed_days;
    logic [9:0]           leap_count;
    logic [DAYS_W-1:0]    days_sum;
    logic signed [DAYS_W-1:0] days_next;

    logic signed [48:0]   day_ms;
    logic [26:0]          hour_ms;
    logic [21:0]          minute_ms;
    logic [OFFSET_W-1:0]  offset_next;

    // a stage moves when its successor is empty or moving on
    assign out_adv = !out_vld_reg || offset_chan.ready;
    assign dc_adv  = !dc_vld_reg  || out_adv;
    assign yt_adv  = !yt_vld_reg  || dc_adv;
    assign in_adv  = !in_vld_reg  || yt_adv;

    assign date_chan.ready = in_adv;

    assign offset_chan.valid            = out_vld_reg;
    assign offset_chan.tt_offset_millis = $signed(offset_reg);

    // year clamp and per-year quotients
    always_comb
    begin
        if ({2'b00, year_reg} > TOP_YEAR)
        begin
            year_clamped = TOP_YEAR[YEAR_W-1:0];
        end
        else
        begin
            year_clamped = year_reg;
        end
    end

    utcj_year_terms u_year_terms (
        .year  (year_clamped),
        .terms (terms)
    );

    // day count: leap rule, month table, elapsed years and leap days
    always_comb
    begin
        year_quarter = yt_year_reg[YEAR_W-1:2];
        year_rem25   = ELAPSED_W'(year_quarter)
                     - ELAPSED_W'({4'd0, yt_terms_reg.year_q25} * 12'd25);
        // year divisible by 100, and by 400 when also divisible by 16
        is_century   = (yt_year_reg[1:0] == 2'b00) && (year_rem25 == '0);
        is_leap      = (yt_year_reg[1:0] == 2'b00)
                     && (!is_century || (yt_year_reg[3:2] == 2'b00));

        doy = days_before(yt_month_reg);
        if ((yt_month_reg >= 4'd3) && is_leap)
        begin
            doy = doy + 9'd1;
        end

        elapsed_days = DAYS_W'({9'd0, yt_terms_reg.elapsed} * 21'd365);
        leap_count   = 10'(({1'b0, yt_terms_reg.elapsed} + 13'd3) >> 2)
                     - {2'b00, yt_terms_reg.cent_q25}
                     + {2'b00, yt_terms_reg.quad_q25};

        days_sum  = elapsed_days + DAYS_W'(doy) + DAYS_W'(leap_count)
                  + DAYS_W'(yt_day_reg);
        // day numbers start at one
        days_next = $signed(days_sum) - DAYS_W'(1);
    end

    // milliseconds, wrapping at the output width
    always_comb
    begin
        day_ms      = dc_days_reg * 28'sd86400000;
        hour_ms     = {22'd0, dc_hour_reg} * 27'(MS_PER_HOUR);
        minute_ms   = {16'd0, dc_minute_reg} * 22'(MS_PER_MINUTE);
        offset_next = day_ms[OFFSET_W-1:0]
                    + OFFSET_W'(hour_ms)
                    + OFFSET_W'(minute_ms)
                    + OFFSET_W'(dc_msec_reg)
                    - OFFSET_W'(REF_OFFSET_MS);
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            yt_vld_reg  <= 1'b0;
            dc_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_adv)
            begin
                in_vld_reg <= date_chan.valid;
            end
            if (yt_adv)
            begin
                yt_vld_reg <= in_vld_reg;
            end
            if (dc_adv)
            begin
                dc_vld_reg <= yt_vld_reg;
            end
            if (out_adv)
            begin
                out_vld_reg <= dc_vld_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_adv && date_chan.valid)
        begin
            year_reg   <= date_chan.calendar_year;
            month_reg  <= date_chan.month_number;
            day_reg    <= date_chan.day_of_month;
            hour_reg   <= date_chan.hour_of_day;
            minute_reg <= date_chan.minute_of_hour;
            msec_reg   <= date_chan.second_millis;
        end
        if (yt_adv && in_vld_reg)
        begin
            yt_year_reg   <= year_clamped;
            yt_terms_reg  <= terms;
            yt_month_reg  <= month_reg;
            yt_day_reg    <= day_reg;
            yt_hour_reg   <= hour_reg;
            yt_minute_reg <= minute_reg;
            yt_msec_reg   <= msec_reg;
        end
        if (dc_adv && yt_vld_reg)
        begin
            dc_days_reg   <= days_next;
            dc_hour_reg   <= yt_hour_reg;
            dc_minute_reg <= yt_minute_reg;
            dc_msec_reg   <= yt_msec_reg;
        end
        if (out_adv && dc_vld_reg)
        begin
            offset_reg <= offset_next;
        end
    end
endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import utcj_pkg::*;

    localparam int YEAR_SPAN   = 256;
    localparam int YEAR_TOP    = EPOCH_YEAR + YEAR_SPAN - 1;
    localparam int N_DIRECTED  = 20;
    localparam int PHASE_DATES = 400;
    localparam int N_PHASES    = 3;
    // slowest phase: one side idle 76% of cycles
    localparam int CYCLE_LIMIT = 200000;
    // four register stages from accept to offset valid, plus margin
    localparam int DRAIN_CYCLES = 8;

    // days before each month in a common year; the last entry is a full year
    localparam int CUM_DAYS [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334,
                                      365};

    // one date request as it goes onto the input channel
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [MSEC_W-1:0]   msec;
    } date_req_t;

    // directed row: a date, plus an offset typed in where it is obvious
    typedef struct packed {
        logic [YEAR_W-1:0]          year;
        logic [MONTH_W-1:0]         month;
        logic [DAY_W-1:0]           day;
        logic [HOUR_W-1:0]          hour;
        logic [MINUTE_W-1:0]        minute;
        logic [MSEC_W-1:0]          msec;
        bit                         typed;
        logic signed [OFFSET_W-1:0] typed_offset;
    } date_row_t;

    logic clk;
    logic rst_n;

    utcj_date_if   date_chan ();
    utcj_offset_if offset_chan ();

    utc_date_to_j2000_seconds #(
        .YEAR_SPAN (YEAR_SPAN)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .date_chan   (date_chan),
        .offset_chan (offset_chan)
    );

    // offsets still owed by the block, oldest first
    logic signed [OFFSET_W-1:0] offset_q [$];
    logic signed [OFFSET_W-1:0] want_offset;

    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    // directed table: extremes of every field and the special cases
    date_row_t directed_rows [N_DIRECTED] = '{
        // first date after reset: epoch midnight
        '{12'd2000, 4'd1,  5'd1,  5'd0,  6'd0,  16'd0,     1'b1, -44'sd43135816},
        // exactly the reference instant
        '{12'd2000, 4'd1,  5'd1,  5'd11, 6'd58, 16'd55816, 1'b1, 44'sd0},
        // day zero counts as minus one day
        '{12'd2000, 4'd1,  5'd0,  5'd0,  6'd0,  16'd0,     1'b1, -44'sd129535816},
        // month zero adds no month days
        '{12'd2000, 4'd0,  5'd1,  5'd0,  6'd0,  16'd0,     1'b1, -44'sd43135816},
        // one full leap year later
        '{12'd2001, 4'd1,  5'd1,  5'd0,  6'd0,  16'd0,     1'b1, 44'sd31579264184},
        // leap day and the day after in a 400-year leap year
        '{12'd2000, 4'd2,  5'd29, 5'd12, 6'd0,  16'd0,     1'b0, 44'sd0},
        '{12'd2000, 4'd3,  5'd1,  5'd0,  6'd0,  16'd0,     1'b0, 44'sd0},
        // plain leap year, and a century that is not one
        '{12'd2004, 4'd3,  5'd1,  5'd0,  6'd0,  16'd0,     1'b0, 44'sd0},
        '{12'd2100, 4'd3,  5'd1,  5'd0,  6'd0,  16'd0,     1'b0, 44'sd0},
        '{12'd2200, 4'd2,  5'd29, 5'd23, 6'd59, 16'd59999, 1'b0, 44'sd0},
        // before the epoch: no elapsed years, leap rule still on the given year
        '{12'd1999, 4'd3,  5'd1,  5'd0,  6'd0,  16'd0,     1'b0, 44'sd0},
        '{12'd1996, 4'd3,  5'd1,  5'd0,  6'd0,  16'd0,     1'b0, 44'sd0},
        '{12'd0,    4'd12, 5'd31, 5'd23, 6'd59, 16'd60999, 1'b0, 44'sd0},
        // last year of the span, then past it where the year is clamped
        '{12'd2255, 4'd12, 5'd31, 5'd23, 6'd59, 16'd60999, 1'b0, 44'sd0},
        '{12'd2256, 4'd6,  5'd15, 5'd8,  6'd30, 16'd0,     1'b0, 44'sd0},
        '{12'd2400, 4'd3,  5'd1,  5'd0,  6'd0,  16'd0,     1'b0, 44'sd0},
        // month thirteen and above take the whole year
        '{12'd2000, 4'd13, 5'd1,  5'd0,  6'd0,  16'd0,     1'b0, 44'sd0},
        '{12'd2003, 4'd15, 5'd1,  5'd0,  6'd0,  16'd0,     1'b0, 44'sd0},
        // time fields past their usual limits add linearly
        '{12'd2000, 4'd1,  5'd1,  5'd31, 6'd63, 16'd65535, 1'b0, 44'sd0},
        // every bit high
        '{12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 16'd65535, 1'b0, 44'sd0}
    };

    // gregorian leap rule
    function automatic bit is_leap_year(input longint unsigned yr);
        if (yr % 4 != 0) return 1'b0;
        if (yr % 100 != 0) return 1'b1;
        return (yr % 400 == 0);
    endfunction

    // leap years among the first n years from the epoch
    function automatic longint unsigned count_leaps(input longint unsigned n);
        return (n + 3) / 4 - (n + 99) / 100 + (n + 399) / 400;
    endfunction

    // expected millisecond offset from the reference instant for one date
    function automatic logic signed [OFFSET_W-1:0] predict_offset(input date_req_t d);
        longint unsigned yr;
        longint unsigned mon;
        longint unsigned elapsed;
        longint          days;
        longint          total;
        yr = d.year;
        if (yr > YEAR_TOP) yr = YEAR_TOP;
        elapsed = (yr > EPOCH_YEAR) ? yr - EPOCH_YEAR : 0;
        mon = (d.month > 13) ? 13 : d.month;
        days = 0;
        if (mon >= 1)
        begin
            days = CUM_DAYS[mon - 1];
            if (mon >= 3 && is_leap_year(yr)) days++;
        end
        days += longint'(elapsed * 365 + count_leaps(elapsed));
        days += longint'(d.day) - 1;
        total = longint'(d.msec)
              + longint'(d.minute) * longint'(MS_PER_MINUTE)
              + longint'(d.hour) * longint'(MS_PER_HOUR)
              + days * longint'(MS_PER_DAY)
              - longint'(REF_OFFSET_MS);
        return total[OFFSET_W-1:0];
    endfunction

    // mostly well-formed dates in the span; the rest is raw noise on every bit
    function automatic date_req_t random_date();
        date_req_t d;
        if ($urandom_range(99) < 85)
        begin
            d.year   = YEAR_W'($urandom_range(YEAR_TOP, EPOCH_YEAR));
            d.month  = MONTH_W'($urandom_range(12, 1));
            d.day    = DAY_W'($urandom_range(31, 1));
            d.hour   = HOUR_W'($urandom_range(23));
            d.minute = MINUTE_W'($urandom_range(59));
            d.msec   = MSEC_W'($urandom_range(60999));
        end
        else
        begin
            d.year   = YEAR_W'($urandom);
            d.month  = MONTH_W'($urandom);
            d.day    = DAY_W'($urandom);
            d.hour   = HOUR_W'($urandom);
            d.minute = MINUTE_W'($urandom);
            d.msec   = MSEC_W'($urandom);
        end
        return d;
    endfunction

    // drive one date request from a falling edge, hold until accepted,
    // and return at the next falling edge with the expectation queued
    task automatic send_date(input date_req_t d, input logic signed [OFFSET_W-1:0] want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            date_chan.valid <= 1'b0;
            @(negedge clk);
        end
        date_chan.valid          <= 1'b1;
        date_chan.calendar_year  <= d.year;
        date_chan.month_number   <= d.month;
        date_chan.day_of_month   <= d.day;
        date_chan.hour_of_day    <= d.hour;
        date_chan.minute_of_hour <= d.minute;
        date_chan.second_millis  <= d.msec;
        do @(posedge clk); while (date_chan.ready !== 1'b1);
        offset_q.push_back(want);
        @(negedge clk);
    endtask

    // free-running clock, 8 ns period
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // output side back-pressure, changed on the falling edge only
    always @(negedge clk)
    begin
        offset_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // offset checker: every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && offset_chan.valid === 1'b1 && offset_chan.ready === 1'b1)
        begin
            if (offset_q.size() == 0)
            begin
                $display("%0t: offset %0d with no request outstanding",
                         $time, offset_chan.tt_offset_millis);
                mismatch_count++;
            end
            else
            begin
                want_offset = offset_q.pop_front();
                if (offset_chan.tt_offset_millis !== want_offset)
                begin
                    $display("%0t: tt_offset_millis expected %0d actual %0d",
                             $time, want_offset, offset_chan.tt_offset_millis);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d offsets outstanding", $time, offset_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    // main sequence: reset, directed table, three random phases, drain, verdict
    initial
    begin
        date_req_t d;
        date_chan.valid          = 1'b0;
        date_chan.calendar_year  = '0;
        date_chan.month_number   = '0;
        date_chan.day_of_month   = '0;
        date_chan.hour_of_day    = '0;
        date_chan.minute_of_hour = '0;
        date_chan.second_millis  = '0;
        offset_chan.ready        = 1'b0;
        mismatch_count           = 0;
        src_idle_pct             = 37;
        sink_idle_pct            = 76;
        rst_n                    = 1'b0;

        // reset held low from the start, released on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows: typed offsets where obvious, the predictor otherwise
        foreach (directed_rows[i])
        begin
            d = {directed_rows[i].year, directed_rows[i].month, directed_rows[i].day,
                 directed_rows[i].hour, directed_rows[i].minute, directed_rows[i].msec};
            send_date(d, directed_rows[i].typed ? directed_rows[i].typed_offset
                                                : predict_offset(d));
        end

        // receiver-heavy idling, then sender-heavy, then full rate
        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 37;
                    sink_idle_pct = 76;
                end
                1:
                begin
                    src_idle_pct  = 76;
                    sink_idle_pct = 37;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            repeat (PHASE_DATES)
            begin
                d = random_date();
                send_date(d, predict_offset(d));
            end
        end
        date_chan.valid <= 1'b0;

        // let every outstanding offset come out, then wait out the drain margin
        while (offset_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
